// File: hdl/multichannel_highpass_biquad_core_defines.svh
// Assertion macros for the high-pass biquad core checker.
// Used by mhb_checker; expects clk_i and rst_ni in the including scope.
`ifndef MULTICHANNEL_HIGHPASS_BIQUAD_CORE_DEFINES_SVH
`define MULTICHANNEL_HIGHPASS_BIQUAD_CORE_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define MHB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mhb check failed");

// Implication from a condition to a property in the next cycle.
`define MHB_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("mhb check failed");

`endif

// File: hdl/mhb_pkg.sv
// Package for the multichannel high-pass biquad core.
// Widths, register indexes, sequencer states and the 48-bit saturation helper.
package mhb_pkg;

  localparam int DEFAULT_MAX_CHANNELS = 8;
  localparam int DEFAULT_SAMPLE_BITS  = 24;

  localparam int CH_W       = 3;
  localparam int ACT_W      = 4;
  localparam int COEF_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DLY_W      = 48;
  localparam int ACC_W      = 53;
  localparam int PROD_SHIFT = 14;
  localparam int OUT_SHIFT  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE    = 3'd0,
    REG_COEF_B0   = 3'd1,
    REG_COEF_B1   = 3'd2,
    REG_COEF_A1   = 3'd3,
    REG_COEF_A2   = 3'd4,
    REG_ACTIVE_CH = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_B0,
    ST_MUL_B1,
    ST_MUL_A1,
    ST_MUL_A2,
    ST_DONE
  } mhb_state_e;

  function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DLY_W:0] top;
    top = v[ACC_W-1:DLY_W-1];
    if (top == '0 || top == '1) begin
      return v[DLY_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(DLY_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DLY_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: hdl/multichannel_highpass_biquad_core.sv
// Top level of the multichannel high-pass biquad (transposed direct form II).
// Depends on mhb_pkg.
//
// Each accepted sample walks the core through the transfer in idle, then
// four passes through one shared COEF_W x SAMPLE_BITS multiplier (b0*x, b1*x, a1*y,
// a2*y) and a final state that writes the channel's delay pair back and loads the
// output register. in_stall_o is high from the transfer until the sequencer is back
// in idle; it stays high longer only while a finished result waits in the output
// register. Bypassed samples (filter disabled) and bad channels go straight from
// the transfer to that final state. Delay terms live in a one-entry-per-channel
// memory with valid bits that reset clears at once, so reset needs no clearing pass.
module multichannel_highpass_biquad_core #(
  parameter int MAX_CHANNELS = mhb_pkg::DEFAULT_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = mhb_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mhb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mhb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]   sample_in_i,
  input  logic [mhb_pkg::CH_W-1:0]        channel_sel_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]   sample_out_o,
  output logic                            bad_channel_o
);
  import mhb_pkg::*;

  localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CH_CMP_W = 7;
  localparam int PROD_W   = COEF_W + SAMPLE_BITS;
  localparam int SCL_W    = PROD_W - PROD_SHIFT;
  localparam int RND_W    = ACC_W - OUT_SHIFT;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (OUT_SHIFT - 1));

  // configuration registers
  logic                     en_q;
  logic signed [COEF_W-1:0] b0_q, b1_q, a1_q, a2_q;
  logic [ACT_W-1:0]         act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b0;
      b0_q  <= '0;
      b1_q  <= '0;
      a1_q  <= '0;
      a2_q  <= '0;
      act_q <= ACT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ENABLE:    en_q  <= cfg_wdata_i[0];
        REG_COEF_B0:   b0_q  <= cfg_wdata_i[COEF_W-1:0];
        REG_COEF_B1:   b1_q  <= cfg_wdata_i[COEF_W-1:0];
        REG_COEF_A1:   a1_q  <= cfg_wdata_i[COEF_W-1:0];
        REG_COEF_A2:   a2_q  <= cfg_wdata_i[COEF_W-1:0];
        REG_ACTIVE_CH: act_q <= cfg_wdata_i[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  mhb_state_e state_q, state_d;
  logic       in_xfer, out_free, out_load, chan_bad, mult_use_y;
  logic       filt_q, bad_q;
  logic signed [COEF_W-1:0] mult_coef;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;
  assign chan_bad = ({1'b0, channel_sel_i} >= act_q) ||
                    (CH_CMP_W'(channel_sel_i) >= CH_CMP_W'(MAX_CHANNELS));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = (en_q && !chan_bad) ? ST_MUL_B0 : ST_DONE;
        end
      end
      ST_MUL_B0: state_d = ST_MUL_B1;
      ST_MUL_B1: state_d = ST_MUL_A1;
      ST_MUL_A1: state_d = ST_MUL_A2;
      ST_MUL_A2: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    mult_coef  = b0_q;
    mult_use_y = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_MUL_B0: mult_coef = b0_q;
      ST_MUL_B1: mult_coef = b1_q;
      ST_MUL_A1: begin
        mult_coef  = a1_q;
        mult_use_y = 1'b1;
      end
      ST_MUL_A2: begin
        mult_coef  = a2_q;
        mult_use_y = 1'b1;
      end
      ST_DONE:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // delay memory: {d1, d2} per channel, valid bit stands in for the reset value
  logic [2*DLY_W-1:0]      dly_mem [MAX_CHANNELS];
  logic [2*DLY_W-1:0]      mem_rd_q;
  logic [MAX_CHANNELS-1:0] vld_q;
  logic                    rd_vld_q;
  logic [CH_IDX_W-1:0]     rd_idx, ch_q;
  logic                    mem_rd, mem_we;
  logic signed [DLY_W-1:0] d1_rd, d2_rd, d1_new_q, d2_new;

  assign rd_idx = CH_IDX_W'(channel_sel_i);
  assign mem_rd = in_xfer && en_q && !chan_bad;
  assign mem_we = out_load && filt_q;

  always_ff @(posedge clk_i) begin
    if (mem_rd) begin
      mem_rd_q <= dly_mem[rd_idx];
    end
    if (mem_we) begin
      dly_mem[ch_q] <= {d1_new_q, d2_new};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_rd) begin
        rd_vld_q <= vld_q[rd_idx];
      end
      if (mem_we) begin
        vld_q[ch_q] <= 1'b1;
      end
    end
  end

  assign d1_rd = rd_vld_q ? mem_rd_q[2*DLY_W-1:DLY_W] : '0;
  assign d2_rd = rd_vld_q ? mem_rd_q[DLY_W-1:0] : '0;

  // shared multiplier and datapath
  logic signed [SAMPLE_BITS-1:0] x_q, y_q, mult_smp, y_sat;
  logic signed [PROD_W-1:0]      prod_full;
  logic signed [SCL_W-1:0]       prod_q, b0x_q;
  logic signed [ACC_W-1:0]       prod_ext, acc_y, rnd_sum, d1acc_q;
  logic signed [RND_W-1:0]       rnd;
  logic [RND_W-SAMPLE_BITS:0]    rnd_top;

  assign mult_smp  = mult_use_y ? y_q : x_q;
  assign prod_full = PROD_W'(mult_coef) * PROD_W'(mult_smp);
  assign prod_ext  = ACC_W'(prod_q);

  // output rounding, ties up, then clamp to the sample range
  assign acc_y   = prod_ext + ACC_W'(d1_rd);
  assign rnd_sum = acc_y + RND_HALF;
  assign rnd     = rnd_sum[ACC_W-1:OUT_SHIFT];
  assign rnd_top = rnd[RND_W-1:SAMPLE_BITS-1];

  always_comb begin
    if (rnd_top == '0 || rnd_top == '1) begin
      y_sat = rnd[SAMPLE_BITS-1:0];
    end else if (rnd[RND_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  assign d2_new = sat_dly(ACC_W'(b0x_q) - prod_ext);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          x_q  <= sample_in_i;
          ch_q <= rd_idx;
          y_q  <= en_q ? '0 : sample_in_i;
        end
      end
      ST_MUL_B0: prod_q <= prod_full[PROD_W-1:PROD_SHIFT];
      ST_MUL_B1: begin
        b0x_q  <= prod_q;
        y_q    <= y_sat;
        prod_q <= prod_full[PROD_W-1:PROD_SHIFT];
      end
      ST_MUL_A1: begin
        d1acc_q <= prod_ext + ACC_W'(d2_rd);
        prod_q  <= prod_full[PROD_W-1:PROD_SHIFT];
      end
      ST_MUL_A2: begin
        d1_new_q <= sat_dly(d1acc_q - prod_ext);
        prod_q   <= prod_full[PROD_W-1:PROD_SHIFT];
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= 1'b0;
      bad_q  <= 1'b0;
    end else if (in_xfer) begin
      filt_q <= en_q && !chan_bad;
      bad_q  <= en_q && chan_bad;
    end
  end

  // output register
  logic                          out_valid_q, out_bad_q;
  logic signed [SAMPLE_BITS-1:0] out_smp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_smp_q <= y_q;
      out_bad_q <= bad_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_smp_q;
  assign bad_channel_o = out_bad_q;

endmodule

// File: hdl/mhb_checker.sv
// Port-level checker for multichannel_highpass_biquad_core, with its bind.
// Depends on mhb_pkg and multichannel_highpass_biquad_core_defines.svh.
`include "multichannel_highpass_biquad_core_defines.svh"

module mhb_checker #(
  parameter int SAMPLE_BITS = mhb_pkg::DEFAULT_SAMPLE_BITS
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [SAMPLE_BITS-1:0]         sample_out_o,
  input logic                           bad_channel_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // one sample at a time: the core is busy right after each transfer
  `MHB_ASSERT_NEXT(a_busy_after_xfer, in_xfer, in_stall_o)

  // a bad-channel result carries a zero sample
  `MHB_ASSERT(a_bad_is_zero, !(out_valid_o && bad_channel_o) || sample_out_o == '0)

  // a stalled result holds
  `MHB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(sample_out_o) && $stable(bad_channel_o))

endmodule

bind multichannel_highpass_biquad_core mhb_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mhb_checker (.*);

// File: verif/biquad_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the multichannel high-pass biquad core: mirrors the register
// writes, predicts each accepted sample's result and compares it with the output.
// Depends on mhb_pkg.
module biquad_result_checker #(
  parameter int SAMPLE_BITS = mhb_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mhb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mhb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_in_i,
  input  logic [mhb_pkg::CH_W-1:0]        channel_sel_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_out_i,
  input  logic                            bad_channel_i,
  output int                              mismatch_count_o,
  output int                              pending_o
);
  import mhb_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          bad;
  } filter_result_t;

  filter_result_t expected_results[$];

  logic                     filter_on;
  logic signed [COEF_W-1:0] b0_q;
  logic signed [COEF_W-1:0] b1_q;
  logic signed [COEF_W-1:0] a1_q;
  logic signed [COEF_W-1:0] a2_q;
  logic [ACT_W-1:0]         active_q;
  longint                   delay_first[DEFAULT_MAX_CHANNELS];
  longint                   delay_second[DEFAULT_MAX_CHANNELS];

  function automatic longint clamp(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // coefficient times sample, brought to delay-term units (floor shift)
  function automatic longint scale_product(input longint coef, input longint v);
    return (coef * v) >>> PROD_SHIFT;
  endfunction

  function automatic filter_result_t filter_step(input logic signed [SAMPLE_BITS-1:0] x,
                                                 input logic [CH_W-1:0] ch);
    filter_result_t r;
    longint xs;
    longint b0x;
    longint acc;
    longint y;
    r.bad = 1'b0;
    r.sample = x;
    if (!filter_on) return r;
    if (ch >= active_q) begin
      r.sample = '0;
      r.bad = 1'b1;
      return r;
    end
    xs = x;
    b0x = scale_product(b0_q, xs);
    acc = b0x + delay_first[ch];
    // round half up, then clamp; the feedback sees the clamped output
    y = clamp((acc + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT, SAMPLE_BITS);
    delay_first[ch] = clamp(scale_product(b1_q, xs) - scale_product(a1_q, y)
                            + delay_second[ch], DLY_W);
    delay_second[ch] = clamp(b0x - scale_product(a2_q, y), DLY_W);
    r.sample = y[SAMPLE_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    filter_result_t seen;
    filter_result_t want;
    if (!rst_ni) begin
      filter_on = 1'b0;
      b0_q = '0;
      b1_q = '0;
      a1_q = '0;
      a2_q = '0;
      active_q = ACT_W'(1);
      foreach (delay_first[i]) begin
        delay_first[i] = 0;
        delay_second[i] = 0;
      end
      expected_results.delete();
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_ENABLE:    filter_on = cfg_wdata_i[0];
          REG_COEF_B0:   b0_q = cfg_wdata_i;
          REG_COEF_B1:   b1_q = cfg_wdata_i;
          REG_COEF_A1:   a1_q = cfg_wdata_i;
          REG_COEF_A2:   a2_q = cfg_wdata_i;
          REG_ACTIVE_CH: active_q = cfg_wdata_i[ACT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        seen.sample = sample_out_i;
        seen.bad = bad_channel_i;
        if (expected_results.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected transfer, sample_out %0d bad_channel %0b",
                   $time, seen.sample, seen.bad);
        end else begin
          want = expected_results.pop_front();
          if (seen.sample !== want.sample) begin
            mismatch_count_o++;
            $display("%0t: sample_out expected %0d actual %0d",
                     $time, want.sample, seen.sample);
          end
          if (seen.bad !== want.bad) begin
            mismatch_count_o++;
            $display("%0t: bad_channel expected %0b actual %0b",
                     $time, want.bad, seen.bad);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(filter_step(sample_in_i, channel_sel_i));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// File: verif/tb_multichannel_highpass_biquad_core.sv
`timescale 1ns / 100ps
// Testbench top for multichannel_highpass_biquad_core: clock, reset, register
// setup, sample stimulus and output stalls; depends on mhb_pkg and biquad_result_checker.
module tb_multichannel_highpass_biquad_core;
  import mhb_pkg::*;

  localparam int SW          = DEFAULT_SAMPLE_BITS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 205;

  // indexes past the register map; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [SW-1:0]     SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]     SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] CMAX = 32'sh7fff_ffff;
  localparam logic signed [COEF_W-1:0] CMIN = 32'sh8000_0000;

  // roughly a Butterworth low-cut at fs/48, Q2.30
  localparam logic signed [COEF_W-1:0] HP_B0 = 32'sd978800000;
  localparam logic signed [COEF_W-1:0] HP_B1 = -32'sd1957600000;
  localparam logic signed [COEF_W-1:0] HP_A1 = -32'sd1949200000;
  localparam logic signed [COEF_W-1:0] HP_A2 = 32'sd892300000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic signed [SW-1:0]   sample_in = '0;
  logic [CH_W-1:0]        channel_sel = '0;
  logic                   out_stall = 1'b0;
  logic                   in_stall;
  logic                   out_valid;
  logic signed [SW-1:0]   sample_out;
  logic                   bad_channel;
  int                     mismatches;
  int                     pending;
  int unsigned            cycle_count = 0;
  bit                     tx_gaps = 1'b0;
  bit                     rx_gaps = 1'b0;
  bit                     long_hold_req = 1'b0;

  multichannel_highpass_biquad_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .sample_in_i   (sample_in),
    .channel_sel_i (channel_sel),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .sample_out_o  (sample_out),
    .bad_channel_o (bad_channel)
  );

  biquad_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .sample_in_i      (sample_in),
    .channel_sel_i    (channel_sel),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .sample_out_i     (sample_out),
    .bad_channel_i    (bad_channel),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // output side: random stall per result, plus one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      n = rx_gaps ? $urandom_range(0, 5) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= d;
    @(posedge clk_i);
  endtask

  task automatic load_config(input logic en, input logic signed [COEF_W-1:0] b0,
                             input logic signed [COEF_W-1:0] b1,
                             input logic signed [COEF_W-1:0] a1,
                             input logic signed [COEF_W-1:0] a2,
                             input logic [ACT_W-1:0] act);
    write_reg(REG_ENABLE, {{(CFG_DATA_W-1){1'b0}}, en});
    write_reg(REG_COEF_B0, b0);
    write_reg(REG_COEF_B1, b1);
    write_reg(REG_COEF_A1, a1);
    write_reg(REG_COEF_A2, a2);
    write_reg(REG_ACTIVE_CH, {{(CFG_DATA_W-ACT_W){1'b0}}, act});
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    cfg_we <= 1'b0;
  endtask

  // valid stays high into the next sample when no gap is drawn
  task automatic push_sample(input logic signed [SW-1:0] x, input logic [CH_W-1:0] ch);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    sample_in <= x;
    channel_sel <= ch;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? SMAX : SMIN;
      1:       return SW'($signed($urandom_range(0, 511)) - 256);
      default: return SW'($urandom());
    endcase
  endfunction

  function automatic logic [CH_W-1:0] pick_channel(input int act);
    int top;
    top = (act > DEFAULT_MAX_CHANNELS) ? DEFAULT_MAX_CHANNELS : act;
    if (top > 0 && $urandom_range(0, 9) < 8) return CH_W'($urandom_range(0, top - 1));
    return CH_W'($urandom_range(0, 7));
  endfunction

  function automatic logic signed [COEF_W-1:0] extreme_coef();
    case ($urandom_range(0, 2))
      0:       return CMAX;
      1:       return CMIN;
      default: return '0;
    endcase
  endfunction

  initial begin
    int kind;
    int act;
    int jitter;
    logic en;
    logic signed [COEF_W-1:0] c0, c1, c2, c3;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out of reset the filter is off: pass-through, even on unused channels
    push_sample(SMAX, 0);
    push_sample(SMIN, 7);
    push_sample('0, 3);
    push_sample(-1, 5);
    settle();

    load_config(1'b1, HP_B0, HP_B1, HP_A1, HP_A2, 8);
    push_sample(SMAX, 0);
    push_sample(SMAX, 0);
    push_sample(SMIN, 0);
    push_sample('0, 0);
    push_sample(SMIN, 1);
    push_sample(-1, 1);
    push_sample(1, 2);
    settle();

    // full-scale coefficients drive the output and the delay terms into clamping
    load_config(1'b1, CMAX, CMAX, CMIN, CMIN, 3);
    push_sample(SMAX, 0);
    push_sample(SMAX, 0);
    push_sample(SMAX, 0);
    push_sample(SMIN, 1);
    push_sample(SMIN, 1);
    push_sample(SMAX, 3);
    push_sample(SMIN, 7);
    settle();

    // no active channels: everything is flagged
    load_config(1'b1, CMIN, CMIN, CMAX, CMAX, 0);
    push_sample(SMAX, 0);
    push_sample(SMIN, 2);
    settle();

    // count above the channel limit behaves as all channels
    load_config(1'b1, HP_B0, HP_B1, HP_A1, HP_A2, 15);
    push_sample(SMAX, 7);
    push_sample(SMIN, 7);
    settle();

    load_config(1'b0, CMAX, CMIN, CMAX, CMIN, 1);
    push_sample(24'sd1234, 6);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      kind = p % 4;
      tx_gaps = (p > 1);
      rx_gaps = (p != 0);
      en = (kind != 3);
      case (kind)
        0: begin
          jitter = $urandom_range(0, 2097152) - 1048576;
          c0 = HP_B0 + jitter;
          c1 = HP_B1 - 2 * jitter;
          c2 = HP_A1 + jitter;
          c3 = HP_A2 - jitter;
          act = 8;
        end
        1: begin
          c0 = $urandom();
          c1 = $urandom();
          c2 = $urandom();
          c3 = $urandom();
          act = $urandom_range(1, 8);
        end
        2: begin
          c0 = extreme_coef();
          c1 = extreme_coef();
          c2 = extreme_coef();
          c3 = extreme_coef();
          act = $urandom_range(0, 15);
        end
        default: begin
          c0 = $urandom();
          c1 = $urandom();
          c2 = $urandom();
          c3 = $urandom();
          act = $urandom_range(0, 15);
        end
      endcase
      load_config(en, c0, c1, c2, c3, ACT_W'(act));
      // back-to-back samples against a parked output fill the core
      if (p == 1) long_hold_req = 1'b1;
      repeat (PHASE_ITEMS) push_sample(pick_sample(), pick_channel(act));
      settle();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
